// ===== src/itoa_pkg.sv =====
// shared types and character constants for the integer to ascii converter
`timescale 1ns / 1ps

package itoa_pkg;

    // ascii codes used when forming output characters
    localparam logic [7:0] CHAR_ZERO         = 8'd48;
    localparam logic [7:0] CHAR_MINUS        = 8'd45;
    localparam logic [7:0] HEX_LETTER_OFFSET = 8'd55;

    // depth of the queue between classifier and converter
    localparam int QUEUE_DEPTH = 2;

    // per-item control flags carried alongside the magnitude
    typedef struct packed {
        logic hex;
        logic neg;
    } t_item_ctl;

endpackage

// ===== src/integer_to_ascii_converter_core.sv =====
// top level of the integer to ascii text converter
`timescale 1ns / 1ps

// Converts one integer per input beat into its ASCII text, sent one character per
// output beat, most significant character first, with tlast on the final character.
// tuser selects the base: 0 gives signed decimal (leading '-' for negative values),
// 1 gives unsigned uppercase hexadecimal without leading zeros; zero gives "0" in both.
// A front stage negates and classifies each number and drops it into a two-entry queue,
// so the input keeps accepting while the converter works, until that queue is full.
// For decimal the converter runs a shift-and-add-3 binary to decimal loop, one bit per
// cycle; hex skips that loop and takes its digits straight from the magnitude. A
// registered output stage holds a finished character while the next one is prepared, so
// throughput is set by the digit loop and the downstream ready.
module integer_to_ascii_converter_core
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // value, zero pad above
    input  logic                                  s_axis_tuser,  // base_hex
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,  // char_out
    output logic                                  m_axis_tlast   // last_char
);

    logic [VALUE_WIDTH-1:0] w_front_mag;
    t_item_ctl              w_front_ctl;
    logic                   w_q_valid;
    logic                   w_q_ready;
    logic [VALUE_WIDTH-1:0] w_q_mag;
    t_item_ctl              w_q_ctl;

    // sign handling and magnitude ahead of the queue
    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_value    (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_base_hex (s_axis_tuser),
        .o_mag      (w_front_mag),
        .o_ctl      (w_front_ctl)
    );

    // decouples input acceptance from the converter
    itoa_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .o_push_ready (s_axis_tready),
        .i_mag        (w_front_mag),
        .i_ctl        (w_front_ctl),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_mag        (w_q_mag),
        .o_ctl        (w_q_ctl)
    );

    // digit conversion and character output
    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_mag        (w_q_mag),
        .i_ctl        (w_q_ctl),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast)
    );

endmodule

// ===== src/itoa_front.sv =====
// front end: classifies an incoming number and forms its magnitude
`timescale 1ns / 1ps

module itoa_front
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_base_hex,
    output logic [VALUE_WIDTH-1:0] o_mag,
    output t_item_ctl              o_ctl
);

    logic w_neg;

    // sign matters only in decimal mode
    assign w_neg     = !i_base_hex && i_value[VALUE_WIDTH-1];
    assign o_mag     = w_neg ? (~i_value + 1'b1) : i_value;
    assign o_ctl.hex = i_base_hex;
    assign o_ctl.neg = w_neg;

endmodule

// ===== src/itoa_queue.sv =====
// short queue between the front end and the converter
`timescale 1ns / 1ps

module itoa_queue
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push_valid,
    output logic                   o_push_ready,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    input  t_item_ctl              i_ctl,
    output logic                   o_pop_valid,
    input  logic                   i_pop_ready,
    output logic [VALUE_WIDTH-1:0] o_mag,
    output t_item_ctl              o_ctl
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] r_mag [QUEUE_DEPTH];
    t_item_ctl              r_ctl [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic                   w_push;
    logic                   w_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_mag        = r_mag[r_rd_ptr];
    assign o_ctl        = r_ctl[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mag[r_wr_ptr] <= i_mag;
            r_ctl[r_wr_ptr] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue pop did not lower count");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue empty with pointers apart");

endmodule

// ===== src/itoa_back.sv =====
// back end: binary to digit conversion and character serializer
`timescale 1ns / 1ps

module itoa_back
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_item_valid,
    output logic                   o_item_ready,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    input  t_item_ctl              i_ctl,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,
    output logic                   o_m_tlast
);

    // there are at least as many decimal digits as hex digits, so one digit store serves both
    localparam int NDIG       = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int IDX_W      = $clog2(NDIG);
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_FIND = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [NDIG-1:0][3:0]     r_dig, n_dig;
    logic [VALUE_WIDTH-1:0]   r_bin, n_bin;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_neg, n_neg;
    logic                     r_out_valid, n_out_valid;
    logic [7:0]               r_out_char, n_out_char;
    logic                     r_out_last, n_out_last;
    logic                     w_out_free;
    logic [NDIG-1:0][3:0]     w_adj;
    logic [HEX_DIGITS*4-1:0]  w_hex_pad;
    logic [3:0]               w_cur;

    assign w_out_free   = !r_out_valid || i_m_tready;
    assign o_item_ready = (r_state == S_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_char;
    assign o_m_tlast    = r_out_last;
    assign w_cur        = r_dig[r_idx];

    // add-3 correction on every digit before each shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
    end

    always_comb begin
        w_hex_pad = '0;
        for (int b = 0; b < VALUE_WIDTH; b++) begin
            w_hex_pad[b] = i_mag[b];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dig       = r_dig;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_neg = i_ctl.neg;
                    n_cnt = '0;
                    n_bin = i_mag;
                    n_dig = '0;
                    if (i_ctl.hex) begin
                        for (int i = 0; i < HEX_DIGITS; i++) begin
                            n_dig[i] = w_hex_pad[i*4 +: 4];
                        end
                        n_state = S_FIND;
                    end else begin
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                // shift the adjusted digits left, next magnitude bit enters at the bottom
                n_dig = (NDIG*4)'({w_adj, r_bin[VALUE_WIDTH-1]});
                n_bin = r_bin << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                // leading nonzero digit, or the lowest one for zero
                n_idx = '0;
                for (int i = 0; i < NDIG; i++) begin
                    if (r_dig[i] != 4'd0) begin
                        n_idx = IDX_W'(i);
                    end
                end
                n_state = r_neg ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = (w_cur < 4'd10) ? {4'd0, w_cur} + CHAR_ZERO
                                                  : {4'd0, w_cur} + HEX_LETTER_OFFSET;
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dig      <= n_dig;
        r_bin      <= n_bin;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_sign_only_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |-> r_neg)
        else $error("minus sign for a non-negative number");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && r_out_last && (r_out_char == CHAR_MINUS)))
        else $error("text ended on a minus sign");

    a_emit_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_SIGN && r_state == S_EMIT) |-> (r_out_char == CHAR_MINUS))
        else $error("sign state left without a minus beat");

endmodule

// ===== tb/tb_integer_to_ascii_converter_core.sv =====
// testbench for the integer to ascii converter: self-checking streams with random stalls
`timescale 1ns / 1ps

module tb_integer_to_ascii_converter_core;
    import itoa_pkg::*;

    // one output character as the block should send it
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    // holds the text still owed for accepted numbers and checks each character
    class number_text_board;
        t_char_beat pending_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // work out the text of one accepted number and queue its characters
        function void note_number(logic [31:0] value, logic hex);
            logic [7:0]  digits[$];  // least significant character first
            logic [31:0] mag;
            logic        neg;
            logic [3:0]  nib;
            t_char_beat  beat;
            neg = !hex && value[31];
            mag = neg ? -value : value;
            do begin
                if (hex) begin
                    nib = mag[3:0];
                    digits.push_back(nib < 4'd10 ? CHAR_ZERO + nib : HEX_LETTER_OFFSET + nib);
                    mag = mag >> 4;
                end else begin
                    digits.push_back(CHAR_ZERO + 8'(mag % 10));
                    mag = mag / 10;
                end
            end while (mag != 0);
            if (neg) begin
                digits.push_back(CHAR_MINUS);
            end
            while (digits.size() != 0) begin
                beat.ch   = digits.pop_back();
                beat.last = (digits.size() == 0);
                pending_chars.push_back(beat);
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // compare one sent character with the oldest one owed
        task check_char(logic [7:0] ch, logic last);
            t_char_beat want;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("character %02h sent with no number pending", ch));
            end else begin
                want = pending_chars.pop_front();
                if (ch !== want.ch) begin
                    report_mismatch($sformatf("char %02h, wanted %02h", ch, want.ch));
                end
                if (last !== want.last) begin
                    report_mismatch($sformatf("tlast %b, wanted %b on char %02h",
                                              last, want.last, want.ch));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // value
    logic        s_axis_tuser = 1'b0;  // base_hex
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // char_out
    logic        m_axis_tlast;  // last_char

    number_text_board board = new();

    // both sides run without random gaps while set; a requested hold-off still applies
    bit steady = 1'b0;
    // long receiver hold-off in cycles, taken up by the ready process
    int output_holdoff = 0;

    // signed decimal corner cases
    logic [31:0] dec_cases [12] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'h7FFF_FFFF,
        32'h8000_0000, 32'd999_999_999, 32'd1_000_000_000, -32'sd1_000_000_000,
        32'd123_456_789
    };
    // hex corner cases, letters and digits at both ends
    logic [31:0] hex_cases [10] = '{
        32'h0, 32'h1, 32'hF, 32'h10, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'hABCD_EF01, 32'h1234_5678, 32'h9A
    };

    integer_to_ascii_converter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // gap before an item or a character, none during steady stretches
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    // random operand: full range, short magnitudes, powers of ten, extremes
    function automatic logic [31:0] pick_number();
        logic [31:0] v;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
            v = $urandom;
        end else if (pick <= 5) begin
            v = $urandom >> $urandom_range(0, 31);
        end else if (pick <= 7) begin
            v = $urandom_range(0, 20);
        end else if (pick == 8) begin
            v = 32'd1;
            repeat ($urandom_range(0, 9)) v = v * 10;
            v = v - $urandom_range(0, 1);
        end else begin
            v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        // sign flip on the shaped values so short negatives show up too
        if (pick >= 3 && pick <= 8 && $urandom_range(0, 1)) begin
            v = -v;
        end
        return v;
    endfunction

    // offer one number, hold it until the beat is taken, then log it
    task send_number(logic [31:0] value, logic hex);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= hex;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_number(value, hex);
    endtask

    // sender pause until every owed character has come out
    task wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random gap per character, or one long hold-off when asked
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (output_holdoff > 0) begin
                gap = output_holdoff;
                output_holdoff = 0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // output monitor, samples values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners in both bases
        foreach (dec_cases[i]) send_number(dec_cases[i], 1'b0);
        foreach (hex_cases[i]) send_number(hex_cases[i], 1'b1);
        wait_drained();

        // random chunks; chunk 3 backs up the output so the input stalls
        for (int chunk = 0; chunk < 7; chunk++) begin
            steady = (chunk == 3) || ($urandom_range(0, 3) == 0);
            if (chunk == 3) begin
                output_holdoff = 400;
            end
            for (int n = 0; n < 40; n++) begin
                send_number(pick_number(), 1'($urandom_range(0, 1)));
            end
            if (chunk == 4) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (board.errors == 0 && board.pending_chars.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== integer_to_ascii_converter_core.f =====
src/itoa_pkg.sv
src/itoa_front.sv
src/itoa_queue.sv
src/itoa_back.sv
src/integer_to_ascii_converter_core.sv
tb/tb_integer_to_ascii_converter_core.sv
